// ===== hdl/lpcs_pkg.sv =====
// Package for the line-preserving comment stripper.
// Holds character codes, the scan mode type and the scan state struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lpcs_pkg;

    // Default character width and fixed stream field widths
    localparam int CHAR_BITS_DEFAULT = 16;
    localparam int TDATA_W           = 16;
    localparam int FIFO_DEPTH        = 4;

    // Character codes
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    typedef enum logic [1:0] {
        MODE_NORMAL = 2'd0,
        MODE_QUOTED = 2'd1,
        MODE_LINE   = 2'd2,
        MODE_BLOCK  = 2'd3
    } t_scan_mode;

    typedef struct packed {
        t_scan_mode mode;
        logic       quote_is_double;
        logic       escape_pending;
        logic       newline_emitted;
        logic       slash_pending;
        logic       star_pending;
    } t_scan_state;

endpackage

`default_nettype wire

// ===== hdl/lpcs_core.sv =====
// Next-state and result logic of the comment stripper for one character.
// Purely combinational; gives up to two output characters per input.
// Depends on lpcs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lpcs_core #(
    parameter int CW = 16
) (
    input  wire logic [CW-1:0]          i_char,
    input  wire logic                   i_eot,
    input  wire lpcs_pkg::t_scan_state  i_state,
    output lpcs_pkg::t_scan_state       o_state,
    output logic [1:0]                  o_count,
    output logic [CW-1:0]               o_char0,
    output logic [CW-1:0]               o_char1
);

    localparam logic [CW-1:0] C_SLASH  = CW'(lpcs_pkg::CH_SLASH);
    localparam logic [CW-1:0] C_STAR   = CW'(lpcs_pkg::CH_STAR);
    localparam logic [CW-1:0] C_BSLASH = CW'(lpcs_pkg::CH_BSLASH);
    localparam logic [CW-1:0] C_CR     = CW'(lpcs_pkg::CH_CR);
    localparam logic [CW-1:0] C_LF     = CW'(lpcs_pkg::CH_LF);
    localparam logic [CW-1:0] C_SPACE  = CW'(lpcs_pkg::CH_SPACE);
    localparam logic [CW-1:0] C_DQUOTE = CW'(lpcs_pkg::CH_DQUOTE);
    localparam logic [CW-1:0] C_SQUOTE = CW'(lpcs_pkg::CH_SQUOTE);

    logic is_eol;
    logic is_quote;
    logic held;

    assign is_eol   = (i_char == C_CR) || (i_char == C_LF);
    assign is_quote = (i_char == C_DQUOTE) || (i_char == C_SQUOTE);
    assign held     = i_state.slash_pending;

    always_comb begin
        o_state = i_state;
        o_count = 2'd0;
        o_char0 = i_char;
        o_char1 = i_char;
        unique case (i_state.mode)
            lpcs_pkg::MODE_BLOCK: begin
                if (i_state.star_pending && i_char == C_SLASH) begin
                    o_state.star_pending = 1'b0;
                    o_state.mode         = lpcs_pkg::MODE_NORMAL;
                    if (!i_state.newline_emitted) begin
                        o_count = 2'd1;
                        o_char0 = C_SPACE;
                    end
                end else begin
                    o_state.star_pending = (i_char == C_STAR);
                    if (is_eol) begin
                        o_count                 = 2'd1;
                        o_state.newline_emitted = 1'b1;
                    end
                end
            end
            lpcs_pkg::MODE_LINE: begin
                if (is_eol) begin
                    o_count      = 2'd1;
                    o_state.mode = lpcs_pkg::MODE_NORMAL;
                end
            end
            lpcs_pkg::MODE_QUOTED: begin
                o_count = 2'd1;
                if (i_state.escape_pending) begin
                    o_state.escape_pending = 1'b0;
                end else if (i_char == C_BSLASH) begin
                    o_state.escape_pending = 1'b1;
                end else if (i_char == (i_state.quote_is_double ? C_DQUOTE : C_SQUOTE)) begin
                    o_state.mode = lpcs_pkg::MODE_NORMAL;
                end
            end
            lpcs_pkg::MODE_NORMAL: begin
                o_state.slash_pending = 1'b0;
                if (held && i_char == C_SLASH) begin
                    o_state.mode = lpcs_pkg::MODE_LINE;
                end else if (held && i_char == C_STAR) begin
                    o_state.mode            = lpcs_pkg::MODE_BLOCK;
                    o_state.newline_emitted = 1'b0;
                    o_state.star_pending    = 1'b0;
                end else begin
                    // release a held slash ahead of the new character
                    if (held) begin
                        o_count = 2'd1;
                        o_char0 = C_SLASH;
                    end
                    if (i_char == C_SLASH && !i_eot) begin
                        o_state.slash_pending = 1'b1;
                    end else begin
                        o_count = held ? 2'd2 : 2'd1;
                        if (is_quote) begin
                            o_state.mode            = lpcs_pkg::MODE_QUOTED;
                            o_state.quote_is_double = (i_char == C_DQUOTE);
                            o_state.escape_pending  = 1'b0;
                        end
                    end
                end
            end
        endcase
        // a buffer ends: start the next one from the reset state
        if (i_eot) begin
            o_state = '0;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/line_preserving_comment_stripper_top.sv =====
// Top level of the line-preserving comment stripper.
// Input register, per-character core and a small result FIFO.
// Depends on lpcs_pkg and lpcs_core.
//
// Usage:
//   The s_axis channel carries one source character per transaction: tdata
//   holds in_char, tlast marks the last character of a buffer (end_of_text).
//   The m_axis channel carries the stripped text: tdata holds out_char, tlast
//   is set on the last result that one input character produced.
//   Each input gives zero, one or two results; a character held back (a
//   slash waiting for its successor) comes out together with the next one unless the pair opens a comment.
//   Characters pass through the input register and core; results wait in the
//   four-entry FIFO, whose head drives m_axis. Throughput: one character per
//   cycle while each gives at most one result and m_axis_tready stays high;
//   a held-slash release is paced by the single-entry-per-cycle FIFO reads.
//   The input side keeps accepting while results wait in the FIFO; it stalls
//   only when the FIFO cannot take two more results. A stalled receiver
//   holds the FIFO head and backs up into s_axis_tready.
//   Reset (i_rst_n low, synchronous) empties the FIFO and input register
//   and returns the scan to normal text. After any buffer's last character
//   the scan state also returns to normal text.
`timescale 1ns / 1ps
`default_nettype none

module line_preserving_comment_stripper_top #(
    parameter int CHAR_BITS = lpcs_pkg::CHAR_BITS_DEFAULT
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [lpcs_pkg::TDATA_W-1:0]  s_axis_tdata,  // [15:0] in_char
    input  wire logic                          s_axis_tlast,  // end_of_text
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [lpcs_pkg::TDATA_W-1:0]       m_axis_tdata,  // [15:0] out_char
    output logic                               m_axis_tlast   // last_of_run
);

    localparam int CW    = (CHAR_BITS < lpcs_pkg::TDATA_W) ? CHAR_BITS : lpcs_pkg::TDATA_W;
    localparam int DEPTH = lpcs_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int CNTW  = $clog2(DEPTH + 1);

    // Input register
    logic          r_in_valid;
    logic [CW-1:0] r_in_char;
    logic          r_in_eot;

    // Scan state
    lpcs_pkg::t_scan_state r_state;
    lpcs_pkg::t_scan_state n_state;

    // Result FIFO
    logic [CW-1:0]   r_fifo_char [DEPTH];
    logic            r_fifo_last [DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CNTW-1:0] r_count;
    logic [CNTW-1:0] n_count;

    logic [1:0]      core_count;
    logic [CW-1:0]   core_char0;
    logic [CW-1:0]   core_char1;
    logic            pop;
    logic            adv;
    logic            s_accept;
    logic [CNTW-1:0] after_pop;
    logic [PW-1:0]   wr_ptr_p1;

    lpcs_core #(
        .CW (CW)
    ) u_core (
        .i_char  (r_in_char),
        .i_eot   (r_in_eot),
        .i_state (r_state),
        .o_state (n_state),
        .o_count (core_count),
        .o_char0 (core_char0),
        .o_char1 (core_char1)
    );

    assign pop           = m_axis_tvalid && m_axis_tready;
    assign after_pop     = r_count - CNTW'(pop);
    // advance only when the FIFO can take two results
    assign adv           = r_in_valid && (after_pop <= CNTW'(DEPTH - 2));
    assign s_axis_tready = !r_in_valid || adv;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign wr_ptr_p1     = r_wr_ptr + PW'(1);
    assign n_count       = after_pop + (adv ? CNTW'(core_count) : '0);

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = lpcs_pkg::TDATA_W'(r_fifo_char[r_rd_ptr]);
    assign m_axis_tlast  = r_fifo_last[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= '0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_count    <= '0;
        end else begin
            if (s_accept) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_state  <= n_state;
                r_wr_ptr <= r_wr_ptr + PW'(core_count);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= n_count;
        end
    end

    // Payload: no reset
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_char <= s_axis_tdata[CW-1:0];
            r_in_eot  <= s_axis_tlast;
        end
        if (adv && core_count != 2'd0) begin
            r_fifo_char[r_wr_ptr] <= core_char0;
            r_fifo_last[r_wr_ptr] <= (core_count == 2'd1);
        end
        if (adv && core_count == 2'd2) begin
            r_fifo_char[wr_ptr_p1] <= core_char1;
            r_fifo_last[wr_ptr_p1] <= 1'b1;
        end
    end

    // Assertions
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(DEPTH))
        else $error("result FIFO count exceeds depth");

    a_slash_only_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.slash_pending |-> r_state.mode == lpcs_pkg::MODE_NORMAL)
        else $error("held slash outside normal text");

    a_eot_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_eot) |=> (r_state == '0))
        else $error("scan state not cleared after end of buffer");

    a_star_only_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.star_pending |-> r_state.mode == lpcs_pkg::MODE_BLOCK)
        else $error("held star outside block comment");

endmodule

`default_nettype wire
